// File: rtl/bitmap_set_engine_core_assert.svh
// Assertion macros shared by the bitmap set engine RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BITMAP_SET_ENGINE_CORE_ASSERT_SVH
`define BITMAP_SET_ENGINE_CORE_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define BSE_ASSERT_SAME(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define BSE_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/bse_pkg.sv
// Shared types, codes and helper functions of the bitmap set engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bse_pkg;

   localparam int SET_BITS_DEFAULT = 1024;
   localparam int WORD_BITS        = 32;

   typedef enum logic [2:0] {
      KIND_FILL    = 3'd0,
      KIND_TEST    = 3'd1,
      KIND_SET     = 3'd2,
      KIND_CLEAR   = 3'd3,
      KIND_COMBINE = 3'd4,
      KIND_COMPARE = 3'd5,
      KIND_FIND    = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      OP_AND     = 3'd0,
      OP_OR      = 3'd1,
      OP_AND_NOT = 3'd2,
      OP_XOR     = 3'd3,
      OP_NOT     = 3'd4
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic sweep_wr;
      logic scan_rd;
      logic finish_eval;
      logic finish_scan;
      logic finish_zero;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
      logic scan_empty;
      logic word_nonzero;
   } status_type;

   // Position of the most significant set bit; zero for an all-zero word.
   function automatic logic [4:0] lead_one(input logic [WORD_BITS-1:0] value);
      logic [4:0] pos;
      pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (value[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the bitmap words of the set engine.
`timescale 1ns / 1ps
`default_nettype none

module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bse_datapath.sv
// Datapath of the bitmap set engine: item registers, word store, word
// operations, scan pointer and result registers. Depends on bse_pkg, bse_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_set_engine_core_assert.svh"

module bse_datapath #(
   parameter int SET_BITS = bse_pkg::SET_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bse_pkg::cmd_type       cmd,
   output bse_pkg::status_type         status,
   input  wire logic [2:0]             req_kind,
   input  wire logic [9:0]             req_bit_index,
   input  wire logic [4:0]             req_word_index,
   input  wire logic [2:0]             req_combine_op,
   input  wire logic [31:0]            req_other_word,
   input  wire logic                   req_fill_ones,
   input  wire logic                   csr_we,
   input  wire logic [10:0]            csr_set_size,
   output logic                        rsp_bit_value,
   output logic                        rsp_in_range,
   output logic [31:0]                 rsp_word_out,
   output logic                        rsp_words_equal,
   output logic                        rsp_found,
   output logic [9:0]                  rsp_highest_index
);

   localparam int WB        = bse_pkg::WORD_BITS;
   localparam int NUM_WORDS = SET_BITS / bse_pkg::WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CW        = AW + 1;

   // Configuration register.
   logic [10:0] set_size_ff;
   logic [10:0] eff_size;
   logic [6:0]  active_full;
   logic [CW-1:0] active_words;

   // Item registers.
   bse_pkg::kind_type kind_ff;
   bse_pkg::op_type   op_ff;
   logic [4:0]        bit_lo_ff;
   logic [AW-1:0]     addr_ff;
   logic [WB-1:0]     other_ff;
   logic              in_range_ff;
   logic              word_ok_ff;
   logic              fill_ff, fill_in;
   logic [CW-1:0]     ptr_ff, ptr_in;

   // Store ports.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WB-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [WB-1:0] rd_data;
   logic [AW-1:0] req_addr;

   // Word operation results.
   logic [WB-1:0] mask;
   logic [WB-1:0] new_word;
   logic          eval_wr;
   logic          ev_bit;
   logic          ev_range;
   logic [WB-1:0] ev_word;
   logic          ev_equal;

   // Result registers.
   logic          bit_value_ff;
   logic          in_range_out_ff;
   logic [WB-1:0] word_out_ff;
   logic          words_equal_ff;
   logic          found_ff;
   logic [9:0]    highest_ff;

   always_comb begin
      if (32'(set_size_ff) > 32'(SET_BITS)) begin
         eff_size = 11'(SET_BITS);
      end else begin
         eff_size = set_size_ff;
      end
   end

   // Words that hold at least one member, rounded up.
   assign active_full  = {1'b0, eff_size[10:5]} + 7'(|eff_size[4:0]);
   assign active_words = CW'(active_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff <= '0;
      end else if (csr_we) begin
         set_size_ff <= csr_set_size;
      end
   end

   always_comb begin
      if (req_kind == bse_pkg::KIND_COMBINE || req_kind == bse_pkg::KIND_COMPARE) begin
         req_addr = AW'(req_word_index);
      end else begin
         req_addr = AW'(req_bit_index[9:5]);
      end
   end

   // The pointer counts up during a fill and down while scanning.
   always_comb begin
      ptr_in  = ptr_ff;
      fill_in = fill_ff;
      if (cmd.capture) begin
         fill_in = req_fill_ones;
         if (req_kind == bse_pkg::KIND_FIND) begin
            ptr_in = active_words;
         end else begin
            ptr_in = '0;
         end
      end else if (cmd.sweep_wr) begin
         ptr_in = ptr_ff + CW'(1);
      end else if (cmd.scan_rd) begin
         ptr_in = ptr_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         fill_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= bse_pkg::kind_type'(req_kind);
         op_ff       <= bse_pkg::op_type'(req_combine_op);
         bit_lo_ff   <= req_bit_index[4:0];
         addr_ff     <= req_addr;
         other_ff    <= req_other_word;
         in_range_ff <= 32'(req_bit_index) < 32'(eff_size);
         word_ok_ff  <= 32'(req_word_index) < 32'(NUM_WORDS);
      end
   end

   always_comb begin
      mask     = WB'(1) << bit_lo_ff;
      new_word = rd_data;
      eval_wr  = 1'b0;
      ev_bit   = 1'b0;
      ev_range = 1'b0;
      ev_word  = '0;
      ev_equal = 1'b0;
      case (kind_ff)
         bse_pkg::KIND_TEST: begin
            ev_range = in_range_ff;
            ev_bit   = in_range_ff & (|(rd_data & mask));
         end
         bse_pkg::KIND_SET: begin
            ev_range = in_range_ff;
            new_word = rd_data | mask;
            eval_wr  = in_range_ff;
         end
         bse_pkg::KIND_CLEAR: begin
            ev_range = in_range_ff;
            new_word = rd_data & ~mask;
            eval_wr  = in_range_ff;
         end
         bse_pkg::KIND_COMBINE: begin
            case (op_ff)
               bse_pkg::OP_AND:     new_word = rd_data & other_ff;
               bse_pkg::OP_OR:      new_word = rd_data | other_ff;
               bse_pkg::OP_AND_NOT: new_word = rd_data & ~other_ff;
               bse_pkg::OP_XOR:     new_word = rd_data ^ other_ff;
               bse_pkg::OP_NOT:     new_word = ~rd_data;
               default:             new_word = rd_data;
            endcase
            eval_wr = word_ok_ff;
            ev_word = word_ok_ff ? new_word : '0;
         end
         bse_pkg::KIND_COMPARE: begin
            ev_equal = word_ok_ff & (rd_data == other_ff);
         end
         default: begin
            new_word = rd_data;
         end
      endcase
   end

   assign wr_en   = cmd.sweep_wr | (cmd.finish_eval & eval_wr);
   assign wr_addr = cmd.sweep_wr ? AW'(ptr_ff) : addr_ff;
   assign wr_data = cmd.sweep_wr ? {WB{fill_ff}} : new_word;
   assign rd_en   = cmd.capture | cmd.scan_rd;
   assign rd_addr = cmd.scan_rd ? AW'(ptr_ff - CW'(1)) : req_addr;

   bse_ram #(
      .WIDTH (WB),
      .DEPTH (NUM_WORDS)
   ) u_words (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.sweep_last   = (ptr_ff == CW'(NUM_WORDS - 1));
   assign status.scan_empty   = (ptr_ff == '0);
   assign status.word_nonzero = |rd_data;

   always_ff @(posedge clock) begin
      if (cmd.finish_eval) begin
         bit_value_ff    <= ev_bit;
         in_range_out_ff <= ev_range;
         word_out_ff     <= ev_word;
         words_equal_ff  <= ev_equal;
         found_ff        <= 1'b0;
         highest_ff      <= '0;
      end else if (cmd.finish_scan) begin
         bit_value_ff    <= 1'b0;
         in_range_out_ff <= 1'b0;
         word_out_ff     <= '0;
         words_equal_ff  <= 1'b0;
         found_ff        <= 1'b1;
         highest_ff      <= 10'({ptr_ff, bse_pkg::lead_one(rd_data)});
      end else if (cmd.finish_zero) begin
         bit_value_ff    <= 1'b0;
         in_range_out_ff <= 1'b0;
         word_out_ff     <= '0;
         words_equal_ff  <= 1'b0;
         found_ff        <= 1'b0;
         highest_ff      <= '0;
      end
   end

   assign rsp_bit_value     = bit_value_ff;
   assign rsp_in_range      = in_range_out_ff;
   assign rsp_word_out      = word_out_ff;
   assign rsp_words_equal   = words_equal_ff;
   assign rsp_found         = found_ff;
   assign rsp_highest_index = highest_ff;

   `BSE_ASSERT_SAME(a_no_rw_overlap, clock, reset, wr_en, !rd_en,
      "store read and write issued in the same cycle")
   `BSE_ASSERT_SAME(a_scan_hit_nonzero, clock, reset, cmd.finish_scan, status.word_nonzero,
      "scan reported a hit on an empty word")
   `BSE_ASSERT_NEXT(a_ptr_bounded, clock, reset, cmd.capture, 32'(ptr_ff) <= 32'(NUM_WORDS),
      "word pointer loaded beyond the store")

endmodule

`default_nettype wire

// File: rtl/bse_ctrl.sv
// Controller of the bitmap set engine: sequences sweeps, word operations and
// scans, and owns the handshakes. Depends on bse_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_set_engine_core_assert.svh"

module bse_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [2:0]          req_kind,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output bse_pkg::cmd_type         cmd,
   input  wire bse_pkg::status_type status
);

   typedef enum logic [5:0] {
      ST_SWEEP     = 6'b000001,
      ST_IDLE      = 6'b000010,
      ST_EVAL      = 6'b000100,
      ST_SCAN_RD   = 6'b001000,
      ST_SCAN_CHK  = 6'b010000,
      ST_ZERO_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      finish;

   // The result register can be loaded if it is empty or drains this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      reply_in = reply_ff;
      cmd      = '0;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = reply_ff ? ST_ZERO_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  bse_pkg::KIND_FILL: begin
                     reply_in = 1'b1;
                     state_in = ST_SWEEP;
                  end
                  bse_pkg::KIND_TEST,
                  bse_pkg::KIND_SET,
                  bse_pkg::KIND_CLEAR,
                  bse_pkg::KIND_COMBINE,
                  bse_pkg::KIND_COMPARE: state_in = ST_EVAL;
                  bse_pkg::KIND_FIND:    state_in = ST_SCAN_RD;
                  default:               state_in = ST_ZERO_DONE;
               endcase
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               cmd.finish_eval = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            if (status.scan_empty) begin
               state_in = ST_ZERO_DONE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (!status.word_nonzero) begin
               state_in = ST_SCAN_RD;
            end else if (out_free) begin
               cmd.finish_scan = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_ZERO_DONE: begin
            if (out_free) begin
               cmd.finish_zero = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign finish       = cmd.finish_eval | cmd.finish_scan | cmd.finish_zero;
   assign rsp_valid_in = finish | (rsp_valid_ff & rsp_stall);

   // After reset the store is swept to zero without producing a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BSE_ASSERT_SAME(a_finish_needs_slot, clock, reset, finish, out_free,
      "result loaded while the previous one is still held")
   `BSE_ASSERT_SAME(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_EVAL || state_ff == ST_SCAN_CHK || state_ff == ST_ZERO_DONE),
      "result raised outside a finishing state")
   `BSE_ASSERT_NEXT(a_sweep_ends, clock, reset,
      (state_ff == ST_SWEEP) && status.sweep_last, state_ff != ST_SWEEP,
      "sweep continued past the last word")

endmodule

`default_nettype wire

// File: rtl/bitmap_set_engine_core.sv
// Bitmap set engine. Test, set, clear, combine and compare: the item is
// captured in idle, evaluated in the eval state and its result registered;
// the next item is taken once the engine is back in idle. Find highest scans
// words downwards, one store read per word. Fill: one store write per word.
// Reset (synchronous): a clearing pass over all words zeroes the store,
// req_stall stays high meanwhile; configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_set_engine_core #(
   parameter int SET_BITS = bse_pkg::SET_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [9:0]  req_bit_index,
   input  wire logic [4:0]  req_word_index,
   input  wire logic [2:0]  req_combine_op,
   input  wire logic [31:0] req_other_word,
   input  wire logic        req_fill_ones,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_bit_value,
   output logic             rsp_in_range,
   output logic [31:0]      rsp_word_out,
   output logic             rsp_words_equal,
   output logic             rsp_found,
   output logic [9:0]       rsp_highest_index,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [10:0] csr_set_size
);

   bse_pkg::cmd_type    cmd;
   bse_pkg::status_type status;
   logic                csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   bse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bse_datapath #(
      .SET_BITS (SET_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_bit_index     (req_bit_index),
      .req_word_index    (req_word_index),
      .req_combine_op    (req_combine_op),
      .req_other_word    (req_other_word),
      .req_fill_ones     (req_fill_ones),
      .csr_we            (csr_we),
      .csr_set_size      (csr_set_size),
      .rsp_bit_value     (rsp_bit_value),
      .rsp_in_range      (rsp_in_range),
      .rsp_word_out      (rsp_word_out),
      .rsp_words_equal   (rsp_words_equal),
      .rsp_found         (rsp_found),
      .rsp_highest_index (rsp_highest_index)
   );

endmodule

`default_nettype wire
